>>> rtl/battery_and_button_power_supervisor_defines.svh
// Assertion macros for the battery and button power supervisor checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef BATTERY_AND_BUTTON_POWER_SUPERVISOR_DEFINES_SVH
`define BATTERY_AND_BUTTON_POWER_SUPERVISOR_DEFINES_SVH

// same-cycle implication
`define BBPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbps assertion failed");

// next-cycle implication
`define BBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbps assertion failed");

`endif

>>> rtl/bbps_pkg.sv
// Shared types and constants for the battery and button power supervisor.
// No dependencies.
package bbps_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OK_THRESHOLD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CRIT_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME      = 3'd4;

  localparam logic [15:0] RST_AVERAGE_PERIOD = 16'd2500;
  localparam logic [15:0] RST_OK_THRESHOLD   = 16'd6000;
  localparam logic [15:0] RST_LOW_THRESHOLD  = 16'd5400;
  localparam logic [15:0] RST_CRIT_THRESHOLD = 16'd4800;
  localparam logic [15:0] RST_HOLD_TIME      = 16'd5000;

  localparam logic [1:0] REASON_NONE = 2'd0;
  localparam logic [1:0] REASON_HOLD = 2'd1;
  localparam logic [1:0] REASON_CRIT = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
    logic [15:0] sample_mv;
  } tick_t;

  typedef struct packed {
    logic [15:0] average_out_mv;
    logic        battery_low_flag;
    logic        button_flag;
    logic        stop_request;
    logic [1:0]  power_off_reason;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic mul_a;
    logic mul_b;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/bbps_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; no other dependencies.
interface bbps_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/battery_and_button_power_supervisor.sv
// Battery and button power supervisor. One tick transaction in gives one
// status transaction out. A tick occupies the block from acceptance to the
// result being loaded into the output register (capture, prep, two multiply
// steps, a 16-step restoring divide by the period, emit); the very first
// tick after reset skips the average math and goes from prep to emit. A
// new tick is accepted the cycle after the result is loaded, while that
// result may still wait downstream.
// Depends on bbps_pkg, bbps_chan_if, bbps_ctrl and bbps_datapath.
module battery_and_button_power_supervisor
  import bbps_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bbps_chan_if.sink              tick,
  bbps_chan_if.source            status
);

  cmd_t       cmd;
  dp_status_t dp_status;
  tick_t      tick_data;
  status_t    status_data;

  assign tick_data   = tick.data;
  assign status.data = status_data;

  bbps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .status     (dp_status),
    .cmd        (cmd)
  );

  bbps_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_data (tick_data),
    .cmd       (cmd),
    .status    (dp_status),
    .out_valid (status.valid),
    .out_ready (status.ready),
    .out_data  (status_data)
  );

endmodule

>>> rtl/bbps_ctrl.sv
// Sequencing state machine for the power supervisor.
// Depends on bbps_pkg; drives commands into bbps_datapath.
module bbps_ctrl
  import bbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tick_valid,
  output logic       tick_ready,
  input  dp_status_t status,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (tick_valid) state_next = ST_PREP;
      ST_PREP:  state_next = status.loaded ? ST_MUL_A : ST_EMIT;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_DIV;
      ST_DIV:   if (status.div_last) state_next = ST_EMIT;
      ST_EMIT:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    tick_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tick_ready  = 1'b1;
        cmd.capture = tick_valid;
      end
      ST_PREP:  cmd.prep     = 1'b1;
      ST_MUL_A: cmd.mul_a    = 1'b1;
      ST_MUL_B: cmd.mul_b    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_EMIT:  cmd.emit     = status.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/bbps_datapath.sv
// Datapath: config registers, button timing, weighted average with a
// shared multiplier and a serial divider, thresholds and output register.
// Depends on bbps_pkg; sequenced by bbps_ctrl.
module bbps_datapath
  import bbps_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  tick_t                  tick_data,
  input  cmd_t                   cmd,
  output dp_status_t             status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output status_t                out_data
);

  logic [15:0] average_period;
  logic [15:0] ok_threshold;
  logic [15:0] low_threshold;
  logic [15:0] crit_threshold;
  logic [15:0] hold_time;

  logic [TIME_BITS-1:0] previous_time;
  logic [TIME_BITS-1:0] press_start_time;
  logic                 button_held;
  logic [15:0]          average_mv;
  logic                 average_loaded;
  logic                 low_flag;

  logic [TIME_BITS-1:0] now_t;
  logic                 down;
  logic [15:0]          sample;
  logic [15:0]          period;
  logic [15:0]          dt;
  logic                 hold_off;
  logic                 stop;
  logic [31:0]          prod;
  logic [15:0]          rem;
  logic [15:0]          quo;
  logic [3:0]           div_cnt;

  logic [TIME_BITS-1:0] held_time;
  logic [TIME_BITS-1:0] gap;
  logic [15:0]          period_nz;
  logic [15:0]          dt_next;
  logic [15:0]          mul_x;
  logic [15:0]          mul_y;
  logic [31:0]          product;
  logic [31:0]          sum;
  logic [16:0]          trial;
  logic                 fits;
  logic [15:0]          rem_next;
  logic [15:0]          quo_next;
  logic                 crit;
  logic                 low_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_period <= RST_AVERAGE_PERIOD;
      ok_threshold   <= RST_OK_THRESHOLD;
      low_threshold  <= RST_LOW_THRESHOLD;
      crit_threshold <= RST_CRIT_THRESHOLD;
      hold_time      <= RST_HOLD_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AVERAGE_PERIOD: average_period <= cfg_data;
        REG_OK_THRESHOLD:   ok_threshold   <= cfg_data;
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        REG_CRIT_THRESHOLD: crit_threshold <= cfg_data;
        REG_HOLD_TIME:      hold_time      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_time = now_t - press_start_time;
    gap       = now_t - previous_time;
    period_nz = (average_period == 16'd0) ? 16'd1 : average_period;
    dt_next   = (gap > TIME_BITS'(period_nz)) ? period_nz : gap[15:0];

    mul_x   = cmd.mul_b ? sample : average_mv;
    mul_y   = cmd.mul_b ? dt : 16'(period - dt);
    product = mul_x * mul_y;
    sum     = prod + product;

    trial    = {rem, quo[15]};
    fits     = trial >= {1'b0, period};
    rem_next = fits ? 16'(trial - {1'b0, period}) : trial[15:0];
    quo_next = {quo[14:0], fits};

    crit     = average_mv <= crit_threshold;
    low_next = low_flag;
    if (average_mv <= low_threshold) begin
      low_next = 1'b1;
    end else if (average_mv >= ok_threshold) begin
      low_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_t  <= TIME_BITS'(tick_data.now_ms);
      down   <= tick_data.button_down;
      sample <= tick_data.sample_mv;
    end
    if (cmd.prep) begin
      period   <= period_nz;
      dt       <= dt_next;
      hold_off <= down && button_held && (held_time > TIME_BITS'(hold_time));
      stop     <= down && !button_held;
    end
    if (cmd.mul_a) begin
      prod <= product;
    end
    if (cmd.mul_b) begin
      rem <= sum[31:16];
      quo <= sum[15:0];
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.emit) begin
      out_data.average_out_mv   <= average_mv;
      out_data.battery_low_flag <= low_next;
      out_data.button_flag      <= button_held;
      out_data.stop_request     <= stop;
      out_data.power_off_reason <= hold_off ? REASON_HOLD :
                                   (crit ? REASON_CRIT : REASON_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time    <= '0;
      press_start_time <= '0;
      button_held      <= 1'b0;
      average_mv       <= '0;
      average_loaded   <= 1'b0;
      low_flag         <= 1'b0;
      div_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.prep) begin
        previous_time <= now_t;
        if (!down) begin
          button_held <= 1'b0;
        end else if (!button_held) begin
          button_held      <= 1'b1;
          press_start_time <= now_t;
        end
        if (!average_loaded) begin
          average_mv     <= sample;
          average_loaded <= 1'b1;
        end
      end
      if (cmd.mul_b) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 4'd1;
        if (div_cnt == 4'd15) begin
          average_mv <= quo_next;
        end
      end
      if (cmd.emit) begin
        low_flag  <= low_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.loaded   = average_loaded;
  assign status.div_last = div_cnt == 4'd15;
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> rtl/bbps_checker.sv
// Port-level assertions for the power supervisor, bound to the top level.
// Depends on bbps_pkg and the defines header.
`include "battery_and_button_power_supervisor_defines.svh"

module bbps_checker
  import bbps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_data
);

  `BBPS_ASSERT_NEXT(a_one_tick_in_flight, in_valid && in_ready, !in_ready)
  `BBPS_ASSERT_NOW(a_reason_code, out_valid, out_data.power_off_reason == REASON_NONE || out_data.power_off_reason == REASON_HOLD || out_data.power_off_reason == REASON_CRIT)
  `BBPS_ASSERT_NOW(a_stop_on_press, out_valid && out_data.stop_request, out_data.button_flag && out_data.power_off_reason != REASON_HOLD)
  `BBPS_ASSERT_NOW(a_hold_needs_button, out_valid && out_data.power_off_reason == REASON_HOLD, out_data.button_flag)
  `BBPS_ASSERT_NEXT(a_out_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind battery_and_button_power_supervisor bbps_checker u_bbps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tick.valid),
  .in_ready  (tick.ready),
  .out_valid (status.valid),
  .out_ready (status.ready),
  .out_data  (status.data)
);
